FILE: hw/rtl/i8583_pkg.sv
// ----------------------------------------------------------------------------
// i8583_pkg
// Shared types, codes and the fixed field format ROM of the ISO 8583 parser.
// ----------------------------------------------------------------------------
package i8583_pkg;

   typedef enum logic [2:0] {
      ROLE_TYPE   = 3'd0,
      ROLE_BITMAP = 3'd1,
      ROLE_PREFIX = 3'd2,
      ROLE_IND    = 3'd3,
      ROLE_DATA   = 3'd4,
      ROLE_IGNORE = 3'd5
   } role_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_LEN_OVER = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   localparam logic [13:0] LEN_SAT = 14'd9999;
   localparam int unsigned STORE_LIMIT_RESET = 1000;

   // format entry: length, kind, prefix byte count
   typedef struct packed {
      logic [1:0] flag;
      logic [3:0] kind;
      logic [9:0] len;
   } fmt_type;

   function automatic fmt_type mk(input int unsigned l, input int unsigned t,
                                  input int unsigned f);
      fmt_type e;
      e.len  = l[9:0];
      e.kind = t[3:0];
      e.flag = f[1:0];
      return e;
   endfunction

   function automatic fmt_type fmt_rom(input logic [6:0] idx);
      fmt_type e;
      case (idx) inside
         7'd0:  e = mk(8,8,0);    7'd1:  e = mk(19,4,1);
         7'd2:  e = mk(6,2,0);
         7'd3, 7'd4, 7'd5: e = mk(12,2,0);
         7'd6:  e = mk(10,2,0);
         7'd7, 7'd8, 7'd9: e = mk(8,2,0);
         7'd10, 7'd11: e = mk(6,2,0);
         [7'd12:7'd17]: e = mk(4,2,0);
         7'd18: e = mk(3,2,0);
         7'd19, 7'd20: e = mk(6,2,0);
         7'd21: e = mk(3,2,0);    7'd22: e = mk(4,2,0);
         7'd23: e = mk(20,0,0);
         7'd24, 7'd25: e = mk(2,2,0);
         7'd26: e = mk(1,2,0);
         [7'd27:7'd30]: e = mk(8,3,0);
         7'd31, 7'd32: e = mk(11,2,1);
         7'd33: e = mk(28,0,1);   7'd34: e = mk(37,4,1);
         7'd35: e = mk(104,4,2);  7'd36: e = mk(12,0,0);
         7'd37: e = mk(6,0,0);    7'd38: e = mk(2,0,0);
         7'd39: e = mk(3,0,0);    7'd40: e = mk(8,0,0);
         7'd41: e = mk(15,0,0);   7'd42: e = mk(40,0,0);
         7'd43: e = mk(25,0,1);
         [7'd44:7'd46]: e = mk(256,8,2);
         7'd47: e = mk(999,4,2);
         7'd48, 7'd49: e = mk(3,0,0);
         7'd50: e = mk(7,0,0);    7'd51: e = mk(8,8,0);
         7'd52: e = mk(16,2,0);   7'd53: e = mk(999,2,2);
         [7'd54:7'd57]: e = mk(999,0,2);
         7'd58: e = mk(999,0,0);  7'd59: e = mk(999,4,0);
         7'd60: e = mk(999,2,2);  7'd61: e = mk(999,8,2);
         7'd62: e = mk(999,0,2);  7'd63: e = mk(64,8,0);
         7'd64: e = mk(8,8,0);    7'd65: e = mk(1,2,0);
         7'd66: e = mk(2,2,0);
         [7'd67:7'd69]: e = mk(3,2,0);
         7'd70, 7'd71: e = mk(4,2,0);
         7'd72: e = mk(6,2,0);
         [7'd73:7'd80]: e = mk(10,2,0);
         [7'd81:7'd84]: e = mk(12,2,0);
         [7'd85:7'd88]: e = mk(16,2,0);
         7'd89: e = mk(42,2,0);   7'd90: e = mk(1,0,0);
         7'd91: e = mk(2,0,0);    7'd92: e = mk(5,0,0);
         7'd93: e = mk(7,0,0);    7'd94: e = mk(42,0,0);
         7'd95: e = mk(8,8,0);    7'd96: e = mk(16,3,0);
         7'd97: e = mk(25,0,0);
         7'd98, 7'd99: e = mk(11,2,1);
         7'd100: e = mk(17,0,1);
         7'd101, 7'd102: e = mk(28,0,1);
         7'd103: e = mk(100,0,2);
         7'd127: e = mk(8,8,0);
         default: e = mk(999,0,2);
      endcase
      return e;
   endfunction

   // stored byte count of a field
   function automatic logic [9:0] data_count(input fmt_type e, input logic [13:0] len);
      logic [14:0] s;
      s = {1'b0, len} + 15'd1;
      return (e.kind[2:0] != 3'd0) ? s[10:1] : len[9:0];
   endfunction

endpackage

FILE: hw/rtl/i8583_next_field.sv
// ----------------------------------------------------------------------------
// i8583_next_field
// Priority encoder: lowest set bitmap bit above the current field.
// ----------------------------------------------------------------------------
module i8583_next_field #(
   parameter int FIELD_COUNT = 128
) (
   input  logic [127:0] bits,     // bit k is field k+1
   input  logic         wide,
   input  logic [7:0]   from,
   output logic [7:0]   field     // 0 when none
);
   always_comb begin
      field = 8'd0;
      for (int n = FIELD_COUNT; n >= 2; n--) begin
         if (bits[n-1] && (8'(n) > from) && (wide || n <= 64))
            field = 8'(n);
      end
   end
endmodule

FILE: hw/rtl/i8583_csr.sv
// ----------------------------------------------------------------------------
// i8583_csr
// APB-style register port holding store_limit.
// ----------------------------------------------------------------------------
module i8583_csr import i8583_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic [11:0] store_limit
);
   logic [11:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 12'(STORE_LIMIT_RESET);
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         limit_ff <= pwdata[11:0];
      end
   end
   assign store_limit = limit_ff;
   assign prdata = (paddr == 2'd0) ? {20'd0, limit_ff} : 32'd0;
endmodule

FILE: hw/rtl/iso8583_message_parser_top.sv
// ----------------------------------------------------------------------------
// iso8583_message_parser_top
// ISO 8583 byte labeller: tags each message byte with role, field and offset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid/req_ready    | msg_byte, end_of_message
//  rsp     | out       | rsp_valid/rsp_ready    | role .. message_done
//  csr     | in        | psel/penable/pwrite    | store_limit at address 0
//
//  One request per cycle unless stalled; result valid the cycle after acceptance.
//  Parse state and next-field encoder update in the same cycle as the label.
//  A full result register stalls input only while rsp_ready is low.
//  Reset (synchronous) returns parse state to message type, limit to 1000.
// ----------------------------------------------------------------------------
module iso8583_message_parser_top import i8583_pkg::*; #(
   parameter int FIELD_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_role,
   output logic [7:0]  rsp_field_number,
   output logic [7:0]  rsp_value,
   output logic [13:0] rsp_declared_length,
   output logic [9:0]  rsp_position_in_field,
   output logic [11:0] rsp_store_offset,
   output logic        rsp_last_of_field,
   output logic [1:0]  rsp_status,
   output logic        rsp_message_done,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [11:0] store_limit;
   assign csr_pready = 1'b1;

   i8583_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .store_limit(store_limit)
   );

   // parse state
   role_type     phase_ff, phase_in;
   logic [4:0]   hdr_ff, hdr_in;
   logic [127:0] bmp_ff, bmp_in;
   logic         wide_ff, wide_in;
   logic [7:0]   cur_ff, cur_in;
   logic [13:0]  acc_ff, acc_in;
   logic [9:0]   left_ff, left_in;
   logic [9:0]   fpos_ff, fpos_in;
   logic [11:0]  off_ff, off_in;
   logic [1:0]   err_ff, err_in;

   // result register
   logic        rv_ff;
   role_type    r_role;
   logic [7:0]  r_field;
   logic [13:0] r_decl;
   logic [9:0]  r_pos;
   logic [11:0] r_off;
   logic        r_last;
   role_type    o_role_ff;
   logic [7:0]  o_field_ff, o_val_ff;
   logic [13:0] o_decl_ff;
   logic [9:0]  o_pos_ff;
   logic [11:0] o_off_ff;
   logic        o_last_ff, o_done_ff;
   logic [1:0]  o_st_ff;

   wire accept = req_valid && req_ready;
   assign req_ready = !rv_ff || rsp_ready;

   wire [7:0] b = req_msg_byte;
   fmt_type e;
   assign e = fmt_rom(7'(cur_ff - 8'd1));

   // bitmap image with the current byte merged (for end of bitmap)
   logic [127:0] bmp_new;
   logic [3:0]   bi;
   logic         wide_new;
   always_comb begin
      bi = hdr_ff[3:0];
      bmp_new = bmp_ff;
      bmp_new[127 - 8*bi -: 8] = bmp_ff[127 - 8*bi -: 8] | b;
      wide_new = (bi == 4'd0) ? b[7] : wide_ff;
   end

   // field numbered n sits at bit (n-1) in reversed order
   logic [127:0] bits_rev;
   always_comb for (int k = 0; k < 128; k++) bits_rev[k] = bmp_in[127-k];

   logic [7:0] nf;
   i8583_next_field #(.FIELD_COUNT(FIELD_COUNT)) u_nf (
      .bits(bits_rev), .wide(wide_in), .from(cur_in), .field(nf)
   );
   // stage before advance: state with cursor and bitmap, plus the advance request
   logic    adv;
   fmt_type ne;
   assign ne = fmt_rom(7'(nf - 8'd1));

   // two prefix bytes of up to 165 each can reach 16665: one bit above 14
   logic [9:0]  cnt;
   logic [14:0] full;
   logic [7:0]  d;
   logic [14:0] d100;
   logic        ovf;

   always_comb begin
      phase_in = phase_ff; hdr_in = hdr_ff; bmp_in = bmp_ff; wide_in = wide_ff;
      cur_in = cur_ff; acc_in = acc_ff; left_in = left_ff; fpos_in = fpos_ff;
      off_in = off_ff; err_in = err_ff;
      r_role = ROLE_IGNORE; r_field = 8'd0; r_decl = 14'd0; r_pos = 10'd0;
      r_off = 12'd0; r_last = 1'b0; adv = 1'b0;
      d = ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
      d100 = {7'd0, acc_ff[7:0]} * 15'd100;
      full = 15'd0; cnt = 10'd0; ovf = 1'b0;
      case (phase_ff)
         ROLE_TYPE: begin
            r_role = ROLE_TYPE;
            if (hdr_ff >= 5'd1) begin phase_in = ROLE_BITMAP; hdr_in = 5'd0; end
            else hdr_in = hdr_ff + 5'd1;
         end
         ROLE_BITMAP: begin
            r_role = ROLE_BITMAP;
            wide_in = wide_new;
            bmp_in = bmp_new;
            hdr_in = {1'b0, bi} + 5'd1;
            if (hdr_in >= (wide_new ? 5'd16 : 5'd8)) begin
               hdr_in = 5'd0; cur_in = 8'd0; adv = 1'b1;
            end
         end
         ROLE_PREFIX: begin
            r_role = ROLE_PREFIX; r_field = cur_ff;
            if (e.flag >= 2'd2 && hdr_ff == 5'd0) begin
               acc_in = {6'd0, d}; hdr_in = 5'd1;
            end else begin
               full = (e.flag >= 2'd2) ? d100 + {7'd0, d} : {7'd0, d};
               r_decl = (full > {1'b0, LEN_SAT}) ? LEN_SAT : full[13:0];
               hdr_in = 5'd0;
               if (full > {5'd0, e.len}) begin
                  err_in = ST_LEN_OVER; phase_in = ROLE_IGNORE;
               end else begin
                  acc_in = full[13:0];
                  if (e.kind[0]) phase_in = ROLE_IND;
                  else begin
                     cnt = data_count(e, full[13:0]);
                     ovf = ({3'd0, cnt} + {1'b0, off_ff}) >= {1'b0, store_limit};
                     if (ovf) begin err_in = ST_OVERFLOW; phase_in = ROLE_IGNORE; end
                     else if (cnt == 10'd0) begin r_last = 1'b1; adv = 1'b1; end
                     else begin left_in = cnt; phase_in = ROLE_DATA; end
                  end
               end
            end
         end
         ROLE_IND: begin
            r_role = ROLE_IND; r_field = cur_ff; r_decl = acc_ff; r_off = off_ff;
            off_in = off_ff + 12'd1; fpos_in = 10'd1;
            cnt = data_count(e, acc_ff);
            ovf = ({3'd0, cnt} + {1'b0, off_in}) >= {1'b0, store_limit};
            if (ovf) begin err_in = ST_OVERFLOW; phase_in = ROLE_IGNORE; end
            else if (cnt == 10'd0) begin r_last = 1'b1; adv = 1'b1; end
            else begin left_in = cnt; phase_in = ROLE_DATA; end
         end
         ROLE_DATA: begin
            ovf = ({3'd0, left_ff} + {1'b0, off_ff}) >= {1'b0, store_limit};
            if (fpos_ff == 10'd0 && e.flag == 2'd0 && ovf) begin
               err_in = ST_OVERFLOW; phase_in = ROLE_IGNORE;
            end else begin
               r_role = ROLE_DATA; r_field = cur_ff; r_decl = acc_ff;
               r_pos = fpos_ff; r_off = off_ff;
               off_in = off_ff + 12'd1; fpos_in = fpos_ff + 10'd1;
               if (left_ff <= 10'd1) begin
                  left_in = 10'd0; r_last = 1'b1; adv = 1'b1;
               end else left_in = left_ff - 10'd1;
            end
         end
         default: ;
      endcase
   end

   // advance to next field (applied on top of the step result)
   role_type    ph_f;
   logic [7:0]  cur_f;
   logic [9:0]  fp_f, left_f;
   logic [4:0]  hdr_f;
   logic [13:0] acc_f;
   logic [1:0]  err_f;
   always_comb begin
      ph_f = phase_in; cur_f = cur_in; fp_f = fpos_in; hdr_f = hdr_in;
      acc_f = acc_in; left_f = left_in;
      if (adv) begin
         if (nf == 8'd0) ph_f = ROLE_IGNORE;
         else begin
            cur_f = nf; fp_f = 10'd0; hdr_f = 5'd0; acc_f = 14'd0;
            if (ne.flag != 2'd0) ph_f = ROLE_PREFIX;
            else begin
               acc_f = {4'd0, ne.len};
               if (ne.kind[0]) ph_f = ROLE_IND;
               else begin left_f = data_count(ne, {4'd0, ne.len}); ph_f = ROLE_DATA; end
            end
         end
      end
      err_f = err_in;
      if (req_end_of_message && ph_f != ROLE_IGNORE && err_in == ST_OK) err_f = ST_TRUNC;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_message)) begin
         phase_ff <= ROLE_TYPE; hdr_ff <= '0; bmp_ff <= '0; wide_ff <= 1'b0;
         cur_ff <= '0; acc_ff <= '0; left_ff <= '0; fpos_ff <= '0; off_ff <= '0;
         err_ff <= ST_OK;
      end else if (accept) begin
         phase_ff <= ph_f; hdr_ff <= hdr_f; bmp_ff <= bmp_in; wide_ff <= wide_in;
         cur_ff <= cur_f; acc_ff <= acc_f; left_ff <= left_f; fpos_ff <= fp_f;
         off_ff <= off_in; err_ff <= err_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (accept) begin
         rv_ff <= 1'b1;
      end else if (rsp_ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         o_role_ff <= r_role; o_field_ff <= r_field; o_val_ff <= b;
         o_decl_ff <= r_decl; o_pos_ff <= r_pos; o_off_ff <= r_off;
         o_last_ff <= r_last; o_st_ff <= err_f; o_done_ff <= req_end_of_message;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_role = o_role_ff;
   assign rsp_field_number = o_field_ff;
   assign rsp_value = o_val_ff;
   assign rsp_declared_length = o_decl_ff;
   assign rsp_position_in_field = o_pos_ff;
   assign rsp_store_offset = o_off_ff;
   assign rsp_last_of_field = o_last_ff;
   assign rsp_status = o_st_ff;
   assign rsp_message_done = o_done_ff;

   // an end of message always returns parsing to the message type phase
   a_eom_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_message |=> phase_ff == ROLE_TYPE && err_ff == ST_OK)
      else $error("parse state not cleared at message end");
   // once an error is set the parser ignores bytes
   a_err_ignore: assert property (@(posedge clock) disable iff (reset)
      err_ff != ST_OK |-> phase_ff == ROLE_IGNORE)
      else $error("error without ignore phase");
   // result register never dropped while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken over a stalled result");
endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ISO 8583 byte labeller. Whole messages (well
// formed, over-length, store overflow, truncated, trailing and noise) are
// streamed one byte per request under random idling on both sides; every
// labelled byte is checked against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import i8583_pkg::*;

   localparam logic [1:0] REG_STORE_LIMIT = 2'd0;

   // message recipes for the generator
   localparam int MSG_CLEAN    = 0;
   localparam int MSG_OVER_MAX = 1;
   localparam int MSG_CUT      = 2;
   localparam int MSG_TRAILING = 3;
   localparam int MSG_NOISE    = 4;

   typedef struct packed {
      logic [9:0] len;
      logic [3:0] kind;
      logic [1:0] pfx;
   } field_fmt_type;

   typedef struct {
      logic [7:0] data;
      logic       eom;
   } msg_req_type;

   typedef struct {
      role_type    role;
      logic [7:0]  field;
      logic [7:0]  value;
      logic [13:0] decl;
      logic [9:0]  pos;
      logic [11:0] off;
      logic        last;
      logic [1:0]  status;
      logic        done;
   } byte_label_type;

   // ---------------------------------------------------------------- DUT I/O
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_msg_byte = '0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_role;
   logic [7:0]  rsp_field_number;
   logic [7:0]  rsp_value;
   logic [13:0] rsp_declared_length;
   logic [9:0]  rsp_position_in_field;
   logic [11:0] rsp_store_offset;
   logic        rsp_last_of_field;
   logic [1:0]  rsp_status;
   logic        rsp_message_done;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   iso8583_message_parser_top dut (.*);

   // ---------------------------------------------------------------- bench state
   msg_req_type    msg_bytes_q[$];   // requests waiting for the driver
   byte_label_type labels_q[$];      // predicted labels, oldest first
   int          mismatches = 0;
   int          labels_checked = 0;
   int          msgs_queued = 0;
   int          bytes_queued = 0;
   int          status_seen[4] = '{0, 0, 0, 0};
   bit          calm = 1'b0;      // no idling on either side while set
   int          req_gap = 0;
   int          rsp_stall = 0;

   // model copy of the parser
   role_type    ph;
   int unsigned hdr_cnt;
   logic [63:0] bm_word[2];
   bit          wide_bm;
   logic [7:0]  cur_field;
   int unsigned len_acc;
   int unsigned bytes_left;
   logic [9:0]  fld_pos;
   logic [11:0] store_ofs;
   logic [1:0]  err_code;
   int unsigned limit_copy = STORE_LIMIT_RESET;

   initial forever #2 clock = ~clock;

   // ---------------------------------------------------------------- format table
   // Field n (1..128): max or fixed length, kind, prefix byte count.
   function automatic field_fmt_type fmt_of(input int unsigned n);
      field_fmt_type e;
      case (n)
         1, 52, 65, 96, 128:          e = '{10'd8,   4'd8, 2'd0};
         2:                           e = '{10'd19,  4'd4, 2'd1};
         3, 11, 12, 20, 21, 73:       e = '{10'd6,   4'd2, 2'd0};
         4, 5, 6, 82, 83, 84, 85:     e = '{10'd12,  4'd2, 2'd0};
         7, 74, 75, 76, 77, 78, 79, 80, 81:
                                      e = '{10'd10,  4'd2, 2'd0};
         8, 9, 10:                    e = '{10'd8,   4'd2, 2'd0};
         13, 14, 15, 16, 17, 18, 23, 71, 72:
                                      e = '{10'd4,   4'd2, 2'd0};
         19, 22, 68, 69, 70:          e = '{10'd3,   4'd2, 2'd0};
         24:                          e = '{10'd20,  4'd0, 2'd0};
         25, 26, 67:                  e = '{10'd2,   4'd2, 2'd0};
         27, 66:                      e = '{10'd1,   4'd2, 2'd0};
         28, 29, 30, 31:              e = '{10'd8,   4'd3, 2'd0};
         32, 33, 99, 100:             e = '{10'd11,  4'd2, 2'd1};
         34, 102, 103:                e = '{10'd28,  4'd0, 2'd1};
         35:                          e = '{10'd37,  4'd4, 2'd1};
         36:                          e = '{10'd104, 4'd4, 2'd2};
         37:                          e = '{10'd12,  4'd0, 2'd0};
         38:                          e = '{10'd6,   4'd0, 2'd0};
         39, 92:                      e = '{10'd2,   4'd0, 2'd0};
         40, 49, 50:                  e = '{10'd3,   4'd0, 2'd0};
         41:                          e = '{10'd8,   4'd0, 2'd0};
         42:                          e = '{10'd15,  4'd0, 2'd0};
         43:                          e = '{10'd40,  4'd0, 2'd0};
         44:                          e = '{10'd25,  4'd0, 2'd1};
         45, 46, 47:                  e = '{10'd256, 4'd8, 2'd2};
         48:                          e = '{10'd999, 4'd4, 2'd2};
         51, 94:                      e = '{10'd7,   4'd0, 2'd0};
         53, 86, 87, 88, 89:          e = '{10'd16,  4'd2, 2'd0};
         54, 61:                      e = '{10'd999, 4'd2, 2'd2};
         59:                          e = '{10'd999, 4'd0, 2'd0};
         60:                          e = '{10'd999, 4'd4, 2'd0};
         62:                          e = '{10'd999, 4'd8, 2'd2};
         64:                          e = '{10'd64,  4'd8, 2'd0};
         90:                          e = '{10'd42,  4'd2, 2'd0};
         91:                          e = '{10'd1,   4'd0, 2'd0};
         93:                          e = '{10'd5,   4'd0, 2'd0};
         95:                          e = '{10'd42,  4'd0, 2'd0};
         97:                          e = '{10'd16,  4'd3, 2'd0};
         98:                          e = '{10'd25,  4'd0, 2'd0};
         101:                         e = '{10'd17,  4'd0, 2'd1};
         104:                         e = '{10'd100, 4'd0, 2'd2};
         default:                     e = '{10'd999, 4'd0, 2'd2};
      endcase
      return e;
   endfunction

   // bytes a field occupies in the store: packed BCD halves the digit count
   function automatic int unsigned stored_bytes(input field_fmt_type e,
                                                input int unsigned len);
      return (e.kind[2:0] != 3'd0) ? (len + 1) / 2 : len;
   endfunction

   // ---------------------------------------------------------------- parser model
   function automatic int unsigned next_present(input int unsigned from);
      int unsigned top;
      int unsigned k;
      top = wide_bm ? 128 : 64;
      for (int unsigned n = from + 1; n <= top; n++) begin
         k = n - 1;
         if (n >= 2 && bm_word[k >> 6][63 - (k & 63)]) return n;
      end
      return 0;
   endfunction

   task automatic open_field(input int unsigned f);
      field_fmt_type e;
      e = fmt_of(f);
      cur_field = f[7:0];
      fld_pos = '0;
      hdr_cnt = 0;
      len_acc = 0;
      if (e.pfx != 2'd0) begin
         ph = ROLE_PREFIX;
      end else begin
         len_acc = e.len;
         if (e.kind[0]) begin
            ph = ROLE_IND;
         end else begin
            bytes_left = stored_bytes(e, len_acc);
            ph = ROLE_DATA;
         end
      end
   endtask

   task automatic move_on();
      int unsigned f;
      f = next_present(cur_field);
      if (f == 0) ph = ROLE_IGNORE;
      else open_field(f);
   endtask

   task automatic abort_parse(input logic [1:0] code);
      err_code = code;
      ph = ROLE_IGNORE;
   endtask

   // end of prefix/indicator: overflow check, then data or (zero length) next field
   task automatic close_header(output logic last);
      int unsigned cnt;
      last = 1'b0;
      cnt = stored_bytes(fmt_of(cur_field), len_acc);
      if (cnt + store_ofs >= limit_copy) begin
         abort_parse(ST_OVERFLOW);
      end else if (cnt == 0) begin
         last = 1'b1;
         move_on();
      end else begin
         bytes_left = cnt;
         ph = ROLE_DATA;
      end
   endtask

   task automatic clear_parser();
      ph = ROLE_TYPE;
      hdr_cnt = 0;
      bm_word[0] = '0;
      bm_word[1] = '0;
      wide_bm = 1'b0;
      cur_field = '0;
      len_acc = 0;
      bytes_left = 0;
      fld_pos = '0;
      store_ofs = '0;
      err_code = ST_OK;
   endtask

   task automatic label_byte(input logic [7:0] b, input logic eom);
      byte_label_type r;
      field_fmt_type  e;
      int unsigned d, full, i;
      r = '{ROLE_IGNORE, 8'd0, b, 14'd0, 10'd0, 12'd0, 1'b0, ST_OK, eom};
      e = fmt_of(cur_field);
      case (ph)
         ROLE_TYPE: begin
            r.role = ROLE_TYPE;
            hdr_cnt++;
            if (hdr_cnt >= 2) begin
               ph = ROLE_BITMAP;
               hdr_cnt = 0;
            end
         end
         ROLE_BITMAP: begin
            i = hdr_cnt & 15;
            r.role = ROLE_BITMAP;
            if (i == 0) wide_bm = b[7];
            bm_word[(i >> 3) & 1] |= 64'(b) << (56 - 8 * (i & 7));
            hdr_cnt = i + 1;
            if (hdr_cnt >= (wide_bm ? 16 : 8)) begin
               hdr_cnt = 0;
               cur_field = '0;
               move_on();
            end
         end
         ROLE_PREFIX: begin
            d = 10 * b[7:4] + b[3:0];   // nibbles taken as they are, BCD or not
            r.role = ROLE_PREFIX;
            r.field = cur_field;
            if (e.pfx >= 2 && hdr_cnt == 0) begin
               len_acc = d;
               hdr_cnt = 1;
            end else begin
               full = (e.pfx >= 2) ? len_acc * 100 + d : d;
               r.decl = (full > 9999) ? LEN_SAT : full[13:0];
               hdr_cnt = 0;
               if (full > e.len) begin
                  abort_parse(ST_LEN_OVER);
               end else begin
                  len_acc = full;
                  if (e.kind[0]) ph = ROLE_IND;
                  else close_header(r.last);
               end
            end
         end
         ROLE_IND: begin
            r.role = ROLE_IND;
            r.field = cur_field;
            r.decl = len_acc[13:0];
            r.off = store_ofs;
            store_ofs++;
            fld_pos = 10'd1;
            close_header(r.last);
         end
         ROLE_DATA: begin
            // fixed fields without header are checked on their first data byte
            if (fld_pos == 0 && e.pfx == 2'd0 && bytes_left + store_ofs >= limit_copy) begin
               abort_parse(ST_OVERFLOW);
            end else begin
               r.role = ROLE_DATA;
               r.field = cur_field;
               r.decl = len_acc[13:0];
               r.pos = fld_pos;
               r.off = store_ofs;
               store_ofs++;
               fld_pos++;
               if (bytes_left <= 1) begin
                  bytes_left = 0;
                  r.last = 1'b1;
                  move_on();
               end else begin
                  bytes_left--;
               end
            end
         end
         default: ;
      endcase
      if (eom && ph != ROLE_IGNORE && err_code == ST_OK) err_code = ST_TRUNC;
      r.status = err_code;
      if (eom) clear_parser();
      labels_q.push_back(r);
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [7:0] to_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic int pick_gap();
      int unsigned p;
      p = $urandom_range(99);
      if (calm || p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Builds one message. An all-zero field set means pick fields at random.
   task automatic queue_message(input logic [128:1] field_set, input bit wide,
                                input int unsigned max_len, input int recipe);
      logic [128:1]  fb;
      logic [7:0]    msg[$];
      logic [7:0]    bb;
      field_fmt_type e;
      int unsigned   top, len, plen, cnt;
      bit            over_done;
      over_done = 1'b0;
      fb = field_set;
      top = wide ? 128 : 64;
      if (recipe == MSG_NOISE) begin
         repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
      end else begin
         if (fb == '0) begin
            // skip fixed fields too long for a short run
            for (int unsigned n = 2; n <= top; n++) begin
               e = fmt_of(n);
               if (!(e.pfx == 2'd0 && e.len > 64) && $urandom_range(99) < 7) fb[n] = 1'b1;
            end
         end
         fb[1] = wide;
         repeat (2) msg.push_back(8'($urandom));
         for (int unsigned j = 0; j < top / 8; j++) begin
            for (int unsigned k = 0; k < 8; k++) bb[7 - k] = fb[j * 8 + k + 1];
            msg.push_back(bb);
         end
         for (int unsigned n = 2; n <= top; n++) begin
            if (fb[n]) begin
               e = fmt_of(n);
               if (e.pfx != 2'd0) begin
                  len = $urandom_range(0, (e.len < max_len) ? e.len : max_len);
                  plen = len;
                  if (recipe == MSG_OVER_MAX && !over_done) begin
                     plen = e.len + 1;
                     over_done = 1'b1;
                  end
                  if (e.pfx == 2'd2) msg.push_back(to_bcd(plen / 100));
                  msg.push_back(to_bcd(plen % 100));
               end else begin
                  len = e.len;
               end
               if (e.kind[0]) msg.push_back(8'($urandom));
               cnt = stored_bytes(e, len);
               repeat (cnt) msg.push_back(8'($urandom));
            end
         end
         if (recipe == MSG_CUT && msg.size() > 1)
            msg = msg[0:$urandom_range(0, msg.size() - 2)];
         if (recipe == MSG_TRAILING)
            repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
      end
      foreach (msg[i]) msg_bytes_q.push_back('{msg[i], i == msg.size() - 1});
      bytes_queued += msg.size();
      msgs_queued++;
   endtask

   // pause the sender until every predicted label is back
   task automatic wait_drained();
      while (msg_bytes_q.size() != 0 || req_valid || labels_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_store_limit(input int unsigned v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_STORE_LIMIT;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      limit_copy = v & 12'hFFF;
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("%0t mismatch on label %0d: %s got %0d, expected %0d",
               $realtime, labels_checked, what, got, want);
   endtask

   // ---------------------------------------------------------------- driver
   // One nonblocking write per signal per edge; next byte is loaded as soon
   // as the current one is taken, unless a random gap is pending.
   always @(posedge clock) begin
      msg_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (msg_bytes_q.size() != 0) begin
            it = msg_bytes_q.pop_front();
            req_valid <= 1'b1;
            req_msg_byte <= it.data;
            req_end_of_message <= it.eom;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // predict on every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) label_byte(req_msg_byte, req_end_of_message);
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      byte_label_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (labels_q.size() == 0) begin
            report_mismatch("unexpected label, value", rsp_value, 0);
         end else begin
            x = labels_q.pop_front();
            if (rsp_role != x.role) report_mismatch("role", rsp_role, x.role);
            if (rsp_field_number != x.field)
               report_mismatch("field_number", rsp_field_number, x.field);
            if (rsp_value != x.value) report_mismatch("value", rsp_value, x.value);
            if (rsp_declared_length != x.decl)
               report_mismatch("declared_length", rsp_declared_length, x.decl);
            if (rsp_position_in_field != x.pos)
               report_mismatch("position_in_field", rsp_position_in_field, x.pos);
            if (rsp_store_offset != x.off)
               report_mismatch("store_offset", rsp_store_offset, x.off);
            if (rsp_last_of_field != x.last)
               report_mismatch("last_of_field", rsp_last_of_field, x.last);
            if (rsp_status != x.status) report_mismatch("status", rsp_status, x.status);
            if (rsp_message_done != x.done)
               report_mismatch("message_done", rsp_message_done, x.done);
            if (x.done) status_seen[x.status]++;
         end
         labels_checked++;
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin
      #4ms;
      $display("[iso8583_message_parser_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      logic [128:1] fs;
      int unsigned  limits[6];
      int unsigned  target;
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: variable-length fields of kinds 0, 2 and 4 at zero length and a
      // fixed indicator field, then short lengths, a wide bitmap, over-max length,
      // truncation, trailing bytes and extreme byte values. Default store limit.
      fs = '0;
      fs[2] = 1; fs[32] = 1; fs[34] = 1; fs[36] = 1; fs[44] = 1; fs[28] = 1;
      queue_message(fs, 1'b0, 0, MSG_CLEAN);
      fs[104] = 1; fs[128] = 1; fs[97] = 1;
      queue_message(fs, 1'b1, 3, MSG_CLEAN);
      queue_message(fs, 1'b0, 3, MSG_OVER_MAX);
      queue_message(fs, 1'b0, 3, MSG_CUT);
      queue_message(fs, 1'b0, 2, MSG_TRAILING);
      msg_bytes_q.push_back('{8'hFF, 1'b0});
      msg_bytes_q.push_back('{8'h00, 1'b1});
      bytes_queued += 2;
      wait_drained();

      // Random: each store limit setting gets a batch; the extremes force
      // overflow on the first stored byte, or never.
      limits = '{STORE_LIMIT_RESET, 1, 4095, $urandom_range(20, 80),
                 $urandom_range(1, 4095), STORE_LIMIT_RESET};
      foreach (limits[p]) begin
         if (p != 0) write_store_limit(limits[p]);
         calm = (p == 2);
         target = bytes_queued + 70;
         while (bytes_queued < target) begin
            case ($urandom_range(9))
               0:       queue_message('0, $urandom_range(1), 12, MSG_OVER_MAX);
               1:       queue_message('0, $urandom_range(1), 12, MSG_CUT);
               2:       queue_message('0, $urandom_range(1), 12, MSG_TRAILING);
               3:       queue_message('0, 1'b0, 12, MSG_NOISE);
               default: queue_message('0, $urandom_range(99) < 30, 12, MSG_CLEAN);
            endcase
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Streamed %0d messages (%0d bytes) over six store limits; %0d labels checked.",
               msgs_queued, bytes_queued, labels_checked);
      $display("Final status counts ok/over-max/overflow/truncated: %0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && labels_q.size() == 0) begin
         $display("[iso8583_message_parser_top] OK");
      end else begin
         $display("[iso8583_message_parser_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/i8583_pkg.sv
hw/rtl/i8583_next_field.sv
hw/rtl/i8583_csr.sv
hw/rtl/iso8583_message_parser_top.sv
dv/testbench.sv
